// ===== src/tdu8_pkg.sv =====
// Package: shared types, constants and the bit-timer step function for the UART.
`default_nettype none
package tdu8_pkg;

  typedef logic [15:0] count_t;
  typedef logic [3:0]  bits_t;

  localparam count_t BIT_PERIOD_RESET = 16'd104;
  localparam bits_t  FRAME_BITS       = 4'd10;
  localparam bits_t  DATA_BITS        = 4'd8;
  localparam bits_t  RX_HALF_MARK     = 4'd9;

  typedef struct packed {
    logic   fire;
    count_t cnt;
  } tick_t;

  typedef struct packed {
    logic level;
    logic active;
  } tx_status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] hold;
  } rx_status_t;

  // Up-counter step: fires and wraps to zero when the count reaches the limit.
  function automatic tick_t tick_reached(input count_t cnt, input count_t limit);
    tick_t  t;
    count_t c;
    c = cnt + 16'd1;
    if ((c >= limit) || (c == 16'd0)) begin
      t.fire = 1'b1;
      t.cnt  = 16'd0;
    end else begin
      t.fire = 1'b0;
      t.cnt  = c;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/tdu8_if.sv =====
// Interfaces: tick input channel and result channel, valid/ready handshake.
`default_nettype none
interface tdu8_in_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       tx_start;
  logic [7:0] tx_byte;

  modport source (output valid, output rx_line, output tx_start, output tx_byte, input ready);
  modport sink   (input valid, input rx_line, input tx_start, input tx_byte, output ready);
endinterface

interface tdu8_out_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       rx_valid;
  logic [7:0] rx_byte;

  modport source (output valid, output tx_line, output tx_busy, output rx_valid,
                  output rx_byte, input ready);
  modport sink   (input valid, input tx_line, input tx_busy, input rx_valid,
                  input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== src/tdu8_tx.sv =====
// Transmitter: idle lead, start bit, eight data bits LSB first, stop bit.
`default_nettype none
module tdu8_tx (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              tx_start,
  input  wire logic [7:0]        tx_byte,
  input  wire tdu8_pkg::count_t  bit_period,
  output tdu8_pkg::tx_status_t   status_nxt
);

  logic [9:0]        frame_r, frame_nxt;
  tdu8_pkg::bits_t   bits_r, bits_nxt;
  tdu8_pkg::count_t  cnt_r, cnt_nxt;
  logic              active_r, active_nxt;
  logic              level_r, level_nxt;
  tdu8_pkg::tick_t   tick;

  always_comb begin
    frame_nxt  = frame_r;
    bits_nxt   = bits_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    level_nxt  = level_r;
    tick       = tdu8_pkg::tick_reached(cnt_r, bit_period);
    if (active_r) begin
      cnt_nxt = tick.cnt;
      if (tick.fire) begin
        if (bits_r == 4'd0) begin
          active_nxt = 1'b0;
          level_nxt  = 1'b1;
        end else begin
          level_nxt = frame_r[0];
          frame_nxt = {1'b0, frame_r[9:1]};
          bits_nxt  = bits_r - 4'd1;
        end
      end
    end else if (tx_start) begin
      frame_nxt  = {1'b1, tx_byte, 1'b0};
      bits_nxt   = tdu8_pkg::FRAME_BITS;
      cnt_nxt    = 16'd0;
      active_nxt = 1'b1;
      level_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= 10'd0;
      bits_r   <= 4'd0;
      cnt_r    <= 16'd0;
      active_r <= 1'b0;
      level_r  <= 1'b1;
    end else if (step) begin
      frame_r  <= frame_nxt;
      bits_r   <= bits_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      level_r  <= level_nxt;
    end
  end

  assign status_nxt.level  = level_nxt;
  assign status_nxt.active = active_nxt;

endmodule
`default_nettype wire

// ===== src/tdu8_rx.sv =====
// Receiver: falling-edge start detect, mid-bit sampling of eight data bits.
`default_nettype none
module tdu8_rx (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              rx_line,
  input  wire tdu8_pkg::count_t  bit_period,
  output tdu8_pkg::rx_status_t   status_nxt
);

  logic [7:0]        shift_r, shift_nxt;
  tdu8_pkg::bits_t   bits_r, bits_nxt, bits_dec;
  tdu8_pkg::count_t  cnt_r, cnt_nxt;
  logic              active_r, active_nxt;
  logic              prev_r;
  logic [7:0]        hold_r, hold_nxt;
  logic              valid;
  tdu8_pkg::tick_t   half_tick, full_tick;

  always_comb begin
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    hold_nxt   = hold_r;
    valid      = 1'b0;
    bits_dec   = bits_r - 4'd1;
    half_tick  = tdu8_pkg::tick_reached(cnt_r, {1'b0, bit_period[15:1]});
    full_tick  = tdu8_pkg::tick_reached(cnt_r, bit_period);
    if (active_r) begin
      if (bits_r > tdu8_pkg::DATA_BITS) begin
        cnt_nxt = half_tick.cnt;
        if (half_tick.fire) begin
          bits_nxt = tdu8_pkg::DATA_BITS;
        end
      end else begin
        cnt_nxt = full_tick.cnt;
        if (full_tick.fire) begin
          shift_nxt = {rx_line, shift_r[7:1]};
          if (bits_dec == 4'd0) begin
            hold_nxt   = shift_nxt;
            valid      = 1'b1;
            bits_nxt   = tdu8_pkg::DATA_BITS;
            active_nxt = 1'b0;
          end else begin
            bits_nxt = bits_dec;
          end
        end
      end
    end else if (prev_r && !rx_line) begin
      active_nxt = 1'b1;
      cnt_nxt    = 16'd0;
      bits_nxt   = tdu8_pkg::RX_HALF_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 8'd0;
      bits_r   <= tdu8_pkg::DATA_BITS;
      cnt_r    <= 16'd0;
      active_r <= 1'b0;
      prev_r   <= 1'b1;
      hold_r   <= 8'd0;
    end else if (step) begin
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      prev_r   <= rx_line;
      hold_r   <= hold_nxt;
    end
  end

  assign status_nxt.valid = valid;
  assign status_nxt.hold  = hold_nxt;

endmodule
`default_nettype wire

// ===== src/timer_driven_uart_8n1.sv =====
// Top level: tick-driven 8N1 UART transceiver with a registered result channel.
`default_nettype none
// Every input transaction is one timer tick: the sampled receive level plus an
// optional transmit request. Each accepted tick produces exactly one result
// transaction (transmit pin level, busy flag, receive strobe and the last
// received byte), presented in the cycle after acceptance from a single output
// register. A new tick is taken every cycle while that register is empty or
// being drained, so the sustained rate is one tick per clock; a stall on the
// result side holds the input off. The user writes bit_period (reset 104) via
// cfg_we/cfg_wdata only while no tick is in flight; the block does not check.
module timer_driven_uart_8n1 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tdu8_in_if.sink          in_ch,
  tdu8_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  tdu8_pkg::count_t     bit_period_r;
  logic                 out_valid_r;
  logic                 tx_line_r;
  logic                 tx_busy_r;
  logic                 rx_valid_r;
  logic [7:0]           rx_byte_r;
  logic                 step;
  tdu8_pkg::tx_status_t tx_stat;
  tdu8_pkg::rx_status_t rx_stat;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= tdu8_pkg::BIT_PERIOD_RESET;
    end else if (cfg_we) begin
      bit_period_r <= cfg_wdata;
    end
  end

  tdu8_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .tx_start   (in_ch.tx_start),
    .tx_byte    (in_ch.tx_byte),
    .bit_period (bit_period_r),
    .status_nxt (tx_stat)
  );

  tdu8_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_line    (in_ch.rx_line),
    .bit_period (bit_period_r),
    .status_nxt (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tx_line_r  <= tx_stat.level;
      tx_busy_r  <= tx_stat.active;
      rx_valid_r <= rx_stat.valid;
      rx_byte_r  <= rx_stat.hold;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tx_line  = tx_line_r;
  assign out_ch.tx_busy  = tx_busy_r;
  assign out_ch.rx_valid = rx_valid_r;
  assign out_ch.rx_byte  = rx_byte_r;

endmodule
`default_nettype wire

// ===== src/tdu8_checker.sv =====
// Checker: port-level assertions for the UART top level, with its bind.
`default_nettype none
module tdu8_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_tx_line,
  input wire logic       out_tx_busy,
  input wire logic       out_rx_valid,
  input wire logic [7:0] out_rx_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_line) && $stable(out_tx_busy)
      && $stable(out_rx_valid) && $stable(out_rx_byte))
    else $error("result changed while stalled");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result slot");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick gave no result");

  a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_busy |-> out_tx_line)
    else $error("transmit line low while idle");

endmodule

bind timer_driven_uart_8n1 tdu8_checker u_tdu8_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_tx_line  (out_ch.tx_line),
  .out_tx_busy  (out_ch.tx_busy),
  .out_rx_valid (out_ch.rx_valid),
  .out_rx_byte  (out_ch.rx_byte)
);
`default_nettype wire
